[hdl/dsrt_pkg.sv]
// shared types for the distance sort block: controller states, command and status bundles
package dsrt_pkg;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SEEK,
      ST_EMIT_RD,
      ST_EMIT_WAIT
   } dsrt_state_type;

   typedef struct packed {
      logic take;
      logic step;
      logic place;
      logic emit_read;
      logic emit_load;
   } dsrt_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic full;
      logic pos_zero;
      logic key_less;
      logic last_pend;
      logic emit_end;
      logic out_free;
   } dsrt_status_type;

endpackage

[hdl/distance_sort_with_tags.sv]
// distance_sort_with_tags: top level of the stable descending distance sort with index tags
// load: each beat is taken, stepped past each stored entry with a smaller distance, then placed;
//   the first beat of a batch is written at the take, and a beat is dropped there on a full store
// emit: after the last beat, each result beat is a ram read, then a load, the read held while rsp_stall holds a result
// reset: synchronous, active high; clears the batch count, controller state and output valid,
//   the entry ram is not cleared and holds nothing meaningful until written
module distance_sort_with_tags #(
   parameter int MAX_ENTRIES = 64,
   parameter int KEY_WIDTH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel, one distance per beat
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_distance,
   input  logic        req_last_item,
   // response channel, sorted farthest first
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_sprite_index,
   output logic [31:0] rsp_sorted_distance,
   output logic        rsp_last_result
);
   import dsrt_pkg::*;

   // command and status between controller and datapath
   dsrt_cmd_type    cmd;
   dsrt_status_type status;

   // controller: loads beats, walks the insertion point down, then paces emission
   dsrt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // datapath: entry ram kept sorted on every insert, so the batch streams out in order
   // equal distances never shift past each other, which keeps arrival order
   dsrt_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_distance        (req_distance),
      .req_last_item       (req_last_item),
      .cmd                 (cmd),
      .status              (status),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_sprite_index    (rsp_sprite_index),
      .rsp_sorted_distance (rsp_sorted_distance),
      .rsp_last_result     (rsp_last_result)
   );

endmodule

[hdl/dsrt_ram.sv]
// generic single write port, single read port ram with registered read data
module dsrt_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/dsrt_ctrl.sv]
// controller state machine: batch load with insertion, then sorted emission
module dsrt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_last_item,
   output logic                     req_stall,
   input  dsrt_pkg::dsrt_status_type status,
   output dsrt_pkg::dsrt_cmd_type    cmd
);
   import dsrt_pkg::*;

   dsrt_state_type state_ff;
   dsrt_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (!status.full && !status.count_zero) begin
                  state_in = ST_SEEK;
               end else if (req_last_item) begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_SEEK: begin
            if (status.pos_zero || !status.key_less) begin
               state_in = status.last_pend ? ST_EMIT_RD : ST_LOAD;
            end
         end
         ST_EMIT_RD: begin
            if (status.out_free) begin
               state_in = ST_EMIT_WAIT;
            end
         end
         ST_EMIT_WAIT: begin
            state_in = status.emit_end ? ST_LOAD : ST_EMIT_RD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         ST_SEEK: begin
            if (status.pos_zero || !status.key_less) begin
               cmd.place = 1'b1;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_read = status.out_free;
         end
         ST_EMIT_WAIT: begin
            cmd.emit_load = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

[hdl/dsrt_dpath.sv]
// datapath: entry ram, insertion position, batch counter, emit index and output register
module dsrt_dpath #(
   parameter int MAX_ENTRIES = 64,
   parameter int KEY_WIDTH   = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [31:0]               req_distance,
   input  logic                      req_last_item,
   input  dsrt_pkg::dsrt_cmd_type    cmd,
   output dsrt_pkg::dsrt_status_type status,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [5:0]                rsp_sprite_index,
   output logic [31:0]               rsp_sorted_distance,
   output logic                      rsp_last_result
);
   import dsrt_pkg::*;

   localparam int KW    = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
   localparam int AW    = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int EW    = AW + KW;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [AW-1:0]    emit_idx_ff, emit_idx_in;
   logic             last_pend_ff, last_pend_in;
   logic [KW-1:0]    new_key_ff, new_key_in;
   logic [AW-1:0]    new_tag_ff, new_tag_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [5:0]       rsp_index_ff, rsp_index_in;
   logic [31:0]      rsp_dist_ff, rsp_dist_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [EW-1:0]    wr_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [EW-1:0]    rd_data;
   logic [KW-1:0]    rd_key;
   logic [AW-1:0]    rd_tag;
   logic             full;
   logic             count_zero;
   logic             emit_end;

   assign rd_key     = rd_data[KW-1:0];
   assign rd_tag     = rd_data[EW-1:KW];
   assign full       = (count_ff == CNT_W'(MAX_ENTRIES));
   assign count_zero = (count_ff == '0);
   assign emit_end   = ((CNT_W'(emit_idx_ff) + CNT_W'(1)) == count_ff);

   dsrt_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ram ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = {new_tag_ff, new_key_ff};
      rd_en   = 1'b0;
      rd_addr = emit_idx_ff;
      priority if (cmd.take && !full && count_zero) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = {AW'(0), req_distance[KW-1:0]};
      end else if (cmd.take && !full) begin
         rd_en   = 1'b1;
         rd_addr = count_ff[AW-1:0] - AW'(1);
      end else if (cmd.step) begin
         wr_en   = 1'b1;
         wr_data = rd_data;
         rd_en   = (pos_ff > AW'(1));
         rd_addr = pos_ff - AW'(2);
      end else if (cmd.place) begin
         wr_en   = 1'b1;
      end else if (cmd.emit_read) begin
         rd_en   = 1'b1;
      end else begin
         rd_en   = 1'b0;
      end
   end

   // batch bookkeeping
   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      emit_idx_in  = emit_idx_ff;
      last_pend_in = last_pend_ff;
      new_key_in   = new_key_ff;
      new_tag_in   = new_tag_ff;
      if (cmd.take) begin
         last_pend_in = req_last_item;
         if (!full) begin
            count_in   = count_ff + CNT_W'(1);
            pos_in     = count_ff[AW-1:0];
            new_key_in = req_distance[KW-1:0];
            new_tag_in = count_ff[AW-1:0];
         end
      end
      if (cmd.step) begin
         pos_in = pos_ff - AW'(1);
      end
      if (cmd.emit_load) begin
         if (emit_end) begin
            emit_idx_in = '0;
            count_in    = '0;
         end else begin
            emit_idx_in = emit_idx_ff + AW'(1);
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = 6'(rd_tag);
         rsp_dist_in  = 32'(rd_key);
         rsp_last_in  = emit_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         emit_idx_ff  <= '0;
         last_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         emit_idx_ff  <= emit_idx_in;
         last_pend_ff <= last_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      new_key_ff   <= new_key_in;
      new_tag_ff   <= new_tag_in;
      rsp_index_ff <= rsp_index_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.count_zero = count_zero;
   assign status.full       = full;
   assign status.pos_zero   = (pos_ff == '0);
   assign status.key_less   = (rd_key < new_key_ff);
   assign status.last_pend  = last_pend_ff;
   assign status.emit_end   = emit_end;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sprite_index    = rsp_index_ff;
   assign rsp_sorted_distance = rsp_dist_ff;
   assign rsp_last_result     = rsp_last_ff;

endmodule
